### rtl/qrhb_pkg.sv
// Shared types, constants and helpers for the keyword hash bitmap.
// No dependencies; every rtl file refers to it by scoped names.
package qrhb_pkg;

    localparam int MAX_HASH_BITS = 20;
    localparam int ROW_BITS      = MAX_HASH_BITS - 3;   // bitmap kept as byte rows
    localparam int SLOT_FIELD_W  = 20;                  // width of the emitted index
    localparam int HB_W          = 5;
    localparam int ACC_W         = 32;
    localparam int SHAMT_W       = 6;

    localparam logic [ACC_W-1:0]  HASH_MULT    = 32'h4F1B_BCDC;
    localparam logic [HB_W-1:0]   HASH_BITS_RST = HB_W'(20);
    localparam logic [7:0]        ROW_ALL_ONES = 8'hFF;

    typedef enum logic {
        REQ_BYTE  = 1'b0,
        REQ_CLEAR = 1'b1
    } t_req_kind;

    typedef enum logic {
        RES_SLOT  = 1'b0,
        RES_CLEAR = 1'b1
    } t_res_kind;

    // job handed from front to back through the queue
    typedef struct packed {
        t_req_kind        kind;
        logic [ACC_W-1:0] fold;
    } t_job;

    typedef struct packed {
        logic init_busy;    // post-reset sweep running
        logic idle;         // no job in flight
    } t_back_stat;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MUL,
        ST_SLOT,
        ST_READ,
        ST_WRITE,
        ST_REPLY
    } t_back_state;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [HB_W-1:0] eff_bits(input logic [HB_W-1:0] hb);
        logic [HB_W-1:0] b;
        b = hb;
        if (b == '0) begin
            b = HB_W'(1);
        end
        if (b > HB_W'(MAX_HASH_BITS)) begin
            b = HB_W'(MAX_HASH_BITS);
        end
        return b;
    endfunction

endpackage

### rtl/qrhb_front.sv
// Front end: takes request bytes, lowercases and folds them into the accumulator.
// Pushes one job per finished keyword or clear request. Uses qrhb_pkg.
module qrhb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_hold,       // back end still sweeping after reset
    input  logic              i_q_full,
    output logic              o_push,
    output qrhb_pkg::t_job    o_job
);

    logic [qrhb_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [1:0]                 r_lane, n_lane;
    logic [qrhb_pkg::ACC_W-1:0] folded;
    logic                       take;

    assign o_ready = !i_q_full && !i_hold;
    assign take    = i_valid && o_ready;

    assign folded = r_acc ^ (qrhb_pkg::ACC_W'(qrhb_pkg::lower_byte(i_byte))
                             << {r_lane, 3'b000});

    always_comb begin
        n_acc      = r_acc;
        n_lane     = r_lane;
        o_push     = 1'b0;
        o_job.kind = qrhb_pkg::t_req_kind'(i_kind);
        o_job.fold = folded;
        if (take) begin
            if (qrhb_pkg::t_req_kind'(i_kind) == qrhb_pkg::REQ_CLEAR) begin
                o_push = 1'b1;          // keyword in progress is kept
            end else if (i_last) begin
                o_push = 1'b1;
                n_acc  = '0;
                n_lane = '0;
            end else begin
                n_acc  = folded;
                n_lane = r_lane + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_lane <= '0;
        end else begin
            r_acc  <= n_acc;
            r_lane <= n_lane;
        end
    end

endmodule

### rtl/qrhb_fifo.sv
// Two-entry job queue between front and back end.
// Uses qrhb_pkg for the job type.
module qrhb_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qrhb_pkg::t_job    i_job,
    input  logic              i_pop,
    output qrhb_pkg::t_job    o_job,
    output logic              o_full,
    output logic              o_empty
);

    qrhb_pkg::t_job r_slot [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

### rtl/qrhb_back.sv
// Back end: hashes folded keywords, clears bitmap bits, sweeps the bitmap to ones.
// Holds the bitmap memory and the result register. Uses qrhb_pkg.
module qrhb_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [qrhb_pkg::HB_W-1:0]          i_hash_bits,
    input  logic                               i_q_empty,
    input  qrhb_pkg::t_job                     i_job,
    output logic                               o_pop,
    output qrhb_pkg::t_back_stat               o_stat,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output qrhb_pkg::t_res_kind                o_res_kind,
    output logic [qrhb_pkg::SLOT_FIELD_W-1:0]  o_res_slot
);

    qrhb_pkg::t_back_state r_state, n_state;

    logic [7:0] r_bitmap [2**qrhb_pkg::ROW_BITS];

    logic [qrhb_pkg::ROW_BITS-1:0]      r_row, n_row;
    logic                               r_init, n_init;
    logic                               r_reply_clear, n_reply_clear;
    logic [qrhb_pkg::ACC_W-1:0]         r_fold, n_fold;
    logic [qrhb_pkg::ACC_W-1:0]         r_prod, n_prod;
    logic [qrhb_pkg::MAX_HASH_BITS-1:0] r_slot, n_slot;
    logic [7:0]                         r_rdata;
    logic                               r_out_valid, n_out_valid;
    qrhb_pkg::t_res_kind                r_out_kind, n_out_kind;
    logic [qrhb_pkg::SLOT_FIELD_W-1:0]  r_out_slot, n_out_slot;

    logic                               mem_we;
    logic [qrhb_pkg::ROW_BITS-1:0]      mem_wa, mem_ra;
    logic [7:0]                         mem_wd;
    logic [qrhb_pkg::SHAMT_W-1:0]       shamt;
    logic                               out_free;

    assign shamt    = qrhb_pkg::SHAMT_W'(qrhb_pkg::ACC_W)
                      - qrhb_pkg::SHAMT_W'(qrhb_pkg::eff_bits(i_hash_bits));
    assign out_free = !r_out_valid || i_res_ready;
    assign mem_ra   = r_slot[qrhb_pkg::MAX_HASH_BITS-1:3];

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_init        = r_init;
        n_reply_clear = r_reply_clear;
        n_fold        = r_fold;
        n_prod        = r_prod;
        n_slot        = r_slot;
        n_out_valid   = r_out_valid && !i_res_ready;
        n_out_kind    = r_out_kind;
        n_out_slot    = r_out_slot;
        o_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_wa        = r_row;
        mem_wd        = qrhb_pkg::ROW_ALL_ONES;
        unique case (r_state)
            qrhb_pkg::ST_SWEEP: begin
                mem_we = 1'b1;
                n_row  = r_row + 1'b1;
                if (&r_row) begin
                    n_init  = 1'b0;
                    n_state = r_reply_clear ? qrhb_pkg::ST_REPLY : qrhb_pkg::ST_IDLE;
                end
            end
            qrhb_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_job.kind == qrhb_pkg::REQ_CLEAR) begin
                        n_row         = '0;
                        n_reply_clear = 1'b1;
                        n_state       = qrhb_pkg::ST_SWEEP;
                    end else begin
                        n_fold        = i_job.fold;
                        n_reply_clear = 1'b0;
                        n_state       = qrhb_pkg::ST_MUL;
                    end
                end
            end
            qrhb_pkg::ST_MUL: begin
                n_prod  = r_fold * qrhb_pkg::HASH_MULT;   // low 32 bits kept
                n_state = qrhb_pkg::ST_SLOT;
            end
            qrhb_pkg::ST_SLOT: begin
                n_slot  = qrhb_pkg::MAX_HASH_BITS'(r_prod >> shamt);
                n_state = qrhb_pkg::ST_READ;
            end
            qrhb_pkg::ST_READ: begin
                n_state = qrhb_pkg::ST_WRITE;             // row read in flight
            end
            qrhb_pkg::ST_WRITE: begin
                mem_we  = 1'b1;
                mem_wa  = mem_ra;
                mem_wd  = r_rdata & ~(8'h01 << r_slot[2:0]);
                n_state = qrhb_pkg::ST_REPLY;
            end
            qrhb_pkg::ST_REPLY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_reply_clear) begin
                        n_out_kind = qrhb_pkg::RES_CLEAR;
                        n_out_slot = '0;
                    end else begin
                        n_out_kind = qrhb_pkg::RES_SLOT;
                        n_out_slot = qrhb_pkg::SLOT_FIELD_W'(r_slot);
                    end
                    n_state = qrhb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = qrhb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_bitmap[mem_wa] <= mem_wd;
        end
        r_rdata <= r_bitmap[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= qrhb_pkg::ST_SWEEP;
            r_row         <= '0;
            r_init        <= 1'b1;
            r_reply_clear <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_row         <= n_row;
            r_init        <= n_init;
            r_reply_clear <= n_reply_clear;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fold     <= n_fold;
        r_prod     <= n_prod;
        r_slot     <= n_slot;
        r_out_kind <= n_out_kind;
        r_out_slot <= n_out_slot;
    end

    assign o_stat.init_busy = r_init;
    assign o_stat.idle      = (r_state == qrhb_pkg::ST_IDLE) && i_q_empty;
    assign o_res_valid      = r_out_valid;
    assign o_res_kind       = r_out_kind;
    assign o_res_slot       = r_out_slot;

endmodule

### rtl/query_routing_hash_bitmap.sv
// Keyword hash bitmap. Bytes stream in at one per cycle while the queue has room and no
// post-reset sweep runs; a last byte goes through queue pop, multiply, shift, row read,
// row write and result to o_m_tvalid. The back end handles one job at a time; a clear
// sweeps 2**(MAX_HASH_BITS-3) = 131072 bitmap rows, one per cycle, then replies.
// Synchronous active-low reset; afterwards the same full-bitmap sweep runs with
// input ready held low. Config writes wait for an idle back end and empty queue.
module query_routing_hash_bitmap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write: hash_bits
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] byte_value
    input  logic        i_s_tuser,      // [0] req_type
    input  logic        i_s_tlast,      // last_byte
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,      // [19:0] slot_index, [23:20] zero
    output logic        o_m_tuser       // [0] result_kind
);

    logic [qrhb_pkg::HB_W-1:0] r_hash_bits;

    logic                  push, pop, q_full, q_empty;
    qrhb_pkg::t_job        front_job, q_job;
    qrhb_pkg::t_back_stat  back_stat;
    qrhb_pkg::t_res_kind   res_kind;
    logic [qrhb_pkg::SLOT_FIELD_W-1:0] res_slot;

    // config register; written only while the block is quiet
    // (back end idle, queue empty, no job entering the queue this cycle)
    assign o_cfg_ready = back_stat.idle && !push;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_bits <= qrhb_pkg::HASH_BITS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_hash_bits <= i_cfg_data;
        end
    end

    // front: fold bytes, one job per keyword or clear
    qrhb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_kind   (i_s_tuser),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_hold   (back_stat.init_busy),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (front_job)
    );

    // decouples byte intake from the multi-cycle back end
    qrhb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: hash, bitmap update or sweep, result register
    qrhb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hash_bits (r_hash_bits),
        .i_q_empty   (q_empty),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_stat      (back_stat),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res_kind  (res_kind),
        .o_res_slot  (res_slot)
    );

    assign o_m_tuser = res_kind;
    assign o_m_tdata = {{(24 - qrhb_pkg::SLOT_FIELD_W){1'b0}}, res_slot};

    // a clear result never carries a slot index
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == qrhb_pkg::RES_CLEAR) |-> (o_m_tdata == '0))
        else $error("clear result with nonzero slot");

    // nothing accepted while the post-reset sweep runs
    a_init_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.init_busy |-> !o_s_tready)
        else $error("request accepted during init sweep");

    // reset always starts the sweep
    a_init_start: assert property (@(posedge i_clk)
        !i_rst_n |=> back_stat.init_busy && !o_m_tvalid)
        else $error("reset did not start init sweep");

    // the queue is only popped when it holds a job
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

### tb/sv/query_routing_hash_bitmap_tb.sv
// Self-checking testbench for the keyword hash bitmap (query_routing_hash_bitmap).
// Streams keyword bytes and clear requests and checks every slot result against a
// local hash predictor. Needs qrhb_pkg and the block's RTL only.
module query_routing_hash_bitmap_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qrhb_pkg::*;

    // Run limit in cycles. The slowest legal run is about four bitmap sweeps
    // (post-reset plus three clears, 131072 rows each) plus every item with worst sender
    // gaps and receiver stalls; this is several times that.
    localparam int CYCLE_LIMIT     = 3_000_000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int PHASE_ITEMS     = 276;
    localparam int NUM_PHASES      = 7;
    localparam int CLEAR_PHASE     = 3;
    localparam int HOLD_AT_RESULT  = 100;   // start of the long result hold-off
    localparam int HOLD_CYCLES     = 400;
    localparam int MAX_REPORTS     = 40;

    // one input request: kind, raw byte, last-byte flag
    typedef struct {
        t_req_kind  kind;
        logic [7:0] byte_val;
        logic       is_last;
    } kw_req_t;

    // one expected result
    typedef struct {
        t_res_kind   kind;
        logic [19:0] slot;
    } slot_result_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [4:0]  i_cfg_data  = 5'd0;
    logic        i_s_tvalid  = 1'b0;
    logic [7:0]  i_s_tdata   = 8'd0;
    logic        i_s_tuser   = 1'b0;
    logic        i_s_tlast   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        o_cfg_ready;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;

    query_routing_hash_bitmap DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),      // [7:0] byte_value
        .i_s_tuser   (i_s_tuser),      // [0] req_type
        .i_s_tlast   (i_s_tlast),      // last_byte
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),      // [19:0] slot_index, [23:20] zero
        .o_m_tuser   (o_m_tuser)       // [0] result_kind
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Predictor state: fold accumulator, byte lane and the hash_bits setting.
    // The bitmap itself never shows on the outputs, so it is not modeled.
    // ---------------------------------------------------------------------
    logic [31:0]  fold_acc    = 32'd0;
    logic [1:0]   fold_lane   = 2'd0;
    logic [4:0]   hash_bits_q = HASH_BITS_RST;

    kw_req_t      pending_requests[$];
    slot_result_t expected_slots[$];

    int error_count      = 0;
    int results_checked  = 0;
    int keywords_hashed  = 0;
    int clears_sent      = 0;
    int settings_used    = 1;
    int cycle_count      = 0;

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS) begin
            $display("MISMATCH @%0d: %s", cycle_count, what);
        end
        error_count++;
    endtask

    // Expected result of one accepted request.
    task automatic hash_request(input kw_req_t r);
        logic [7:0]  lc;
        logic [31:0] prod;
        logic [31:0] slot;
        int          bits;
        if (r.kind == REQ_CLEAR) begin
            // accumulator and lane untouched: a keyword in progress carries on
            expected_slots.push_back('{RES_CLEAR, 20'd0});
            clears_sent++;
        end else begin
            lc = r.byte_val;
            if (lc >= 8'h41 && lc <= 8'h5A) begin
                lc = lc + 8'h20;       // only A..Z are lowercased
            end
            fold_acc  = fold_acc ^ ({24'd0, lc} << (int'(fold_lane) * 8));
            fold_lane = fold_lane + 2'd1;
            if (r.is_last) begin
                bits = int'(hash_bits_q);
                if (bits < 1) begin
                    bits = 1;
                end
                if (bits > MAX_HASH_BITS) begin
                    bits = MAX_HASH_BITS;
                end
                prod = fold_acc * HASH_MULT;
                slot = prod >> (32 - bits);
                expected_slots.push_back('{RES_SLOT, slot[19:0]});
                fold_acc  = 32'd0;
                fold_lane = 2'd0;
                keywords_hashed++;
            end
        end
    endtask

    task automatic check_result(input logic kind_bit, input logic [19:0] slot);
        slot_result_t want;
        results_checked++;
        if (expected_slots.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: kind=%0d slot=%05h",
                                      kind_bit, slot));
            return;
        end
        want = expected_slots.pop_front();
        if (kind_bit !== want.kind) begin
            report_mismatch($sformatf("result_kind %0d, expected %0d", kind_bit, want.kind));
        end
        if (slot !== want.slot) begin
            report_mismatch($sformatf("slot_index %05h, expected %05h (hash_bits %0d)",
                                      slot, want.slot, hash_bits_q));
        end
    endtask

    // Random wait after each accepted item, broken up by calm stretches with no idling.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(15, 50);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // ---------------------------------------------------------------------
    // Request driver: offers the queued requests, waits a drawn gap after each
    // accepted one, and keeps tvalid/tdata stable while tready is low.
    // ---------------------------------------------------------------------
    kw_req_t tx_item;
    int      tx_wait = 0;
    int      tx_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                hash_request(tx_item);
                tx_wait = draw_wait(tx_calm);
            end
            if (i_s_tvalid && !o_s_tready) begin
                // request still waiting for the block
            end else if (tx_wait > 0) begin
                tx_wait--;
                i_s_tvalid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                tx_item = pending_requests.pop_front();
                i_s_tdata  <= tx_item.byte_val;
                i_s_tuser  <= tx_item.kind;
                i_s_tlast  <= tx_item.is_last;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor: checks each accepted result, stalls at random, and once
    // holds tready low for a long stretch so the block backs up and stalls input.
    // ---------------------------------------------------------------------
    int rx_stall  = 0;
    int rx_calm   = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_result(o_m_tuser, o_m_tdata[19:0]);
                rx_stall = draw_wait(rx_calm);
            end
            if (!hold_done && results_checked == HOLD_AT_RESULT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_slots.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic is_last);
        pending_requests.push_back('{REQ_BYTE, b, is_last});
    endtask

    // clear request: byte and last fields are don't-care, so randomize them
    task automatic push_clear();
        pending_requests.push_back('{REQ_CLEAR, 8'($urandom), 1'($urandom)});
    endtask

    // Mostly letters of both cases so lowercasing is exercised, plus any byte.
    function automatic logic [7:0] random_keyword_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(8'h41, 8'h5A));
            4, 5, 6:    return 8'($urandom_range(8'h61, 8'h7A));
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random keywords until at least n requests are queued; optionally one clear lands mid-keyword.
    task automatic queue_random_keywords(input int n, input bit with_clear);
        int count;
        int len;
        bit clear_done;
        count = 0;
        clear_done = 1'b0;
        while (count < n) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                push_byte(random_keyword_byte(), k == len - 1);
                count++;
                if (with_clear && !clear_done && count >= n / 2 && k < len - 1) begin
                    push_clear();
                    count++;
                    clear_done = 1'b1;
                end
            end
        end
    endtask

    // Block is idle: every request taken and every result back, then settle.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_requests.size() != 0 || i_s_tvalid || expected_slots.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_hash_bits(input logic [4:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        hash_bits_q = value;
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    logic [4:0] hb_plan[NUM_PHASES];

    initial begin
        // Directed part, run at the reset hash_bits of 20.
        push_byte(8'h41, 1'b1);     // 'A': lower edge of the uppercase range
        push_byte(8'h5A, 1'b1);     // 'Z': upper edge
        push_byte(8'h40, 1'b1);     // '@' just below, unchanged
        push_byte(8'h5B, 1'b1);     // '[' just above, unchanged
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        // five bytes: lane wraps back to 0 on the fifth
        push_byte(8'h48, 1'b0);
        push_byte(8'h65, 1'b0);
        push_byte(8'h4C, 1'b0);
        push_byte(8'h6C, 1'b0);
        push_byte(8'h4F, 1'b1);
        // clear while a keyword is in progress: keyword continues afterwards
        push_byte(8'h78, 1'b0);
        push_clear();
        push_byte(8'h59, 1'b1);
        // clear on its own
        push_clear();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hash_bits settings: the extremes (0 clamps up, 31 clamps down), fixed values and randoms
        hb_plan[0] = 5'd1;
        hb_plan[1] = 5'd0;
        hb_plan[2] = 5'd31;
        hb_plan[3] = 5'd7;
        hb_plan[4] = 5'd20;
        hb_plan[5] = 5'($urandom_range(2, 19));
        hb_plan[6] = 5'($urandom_range(0, 31));

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            set_hash_bits(hb_plan[p]);
            @(negedge i_clk);
            queue_random_keywords(PHASE_ITEMS, p == CLEAR_PHASE);
        end

        wait_idle();

        $display("Covered %0d keywords and %0d bitmap clears across %0d hash_bits settings",
                 keywords_hashed, clears_sent, settings_used);
        $display("with %0d results checked, random stalls and a %0d-cycle result hold-off",
                 results_checked, HOLD_CYCLES);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
